>>> hdl/dlcws_pkg.sv
package dlcws_pkg;

	localparam int DIV_W = 51;
	localparam int IN_W = 48;
	localparam int OUT_W = 104;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [26:0] MG_PER_COUNT_K = 27'sd65536000;
	localparam logic [39:0] QUANT_HALF = 40'd12800;
	// floor(x / 100) = (x * Q_RECIP) >> 37 for any 32-bit x
	localparam logic [31:0] Q_RECIP = 32'h51eb851f;

	localparam logic [CFG_IDX_W-1:0] REG_TARE_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARE_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CPG = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_S = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_M = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ZREL = 3'd7;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_MUL_A,
		OP_DIV_A,
		OP_MUL_B,
		OP_DIV_B,
		OP_MED,
		OP_MEDR,
		OP_FILT1,
		OP_FILT2,
		OP_QDIV,
		OP_QMUL,
		OP_SHOW,
		OP_EMIT,
		OP_ZERO
	} dp_op_t;

	typedef struct packed {
		logic cal;
		logic out_free;
		logic div_done;
	} dp_status_t;

endpackage

>>> hdl/dlcws_div.sv
module dlcws_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [dlcws_pkg::DIV_W-1:0]     dividend,
	input  logic [31:0]                     divisor,
	output logic                            done,
	output logic [dlcws_pkg::DIV_W-1:0]     quotient
);
	import dlcws_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] n_q;
	logic [31:0]      rem_q;
	logic [31:0]      dvs_q;
	logic [32:0]      trial;
	logic             fits;

	assign trial = {rem_q, n_q[DIV_W-1]};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			n_q <= {n_q[DIV_W-2:0], fits};
			rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
		end
	end

	assign done = done_q;
	assign quotient = n_q;

endmodule

>>> hdl/dlcws_ctrl.sv
module dlcws_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_fire,
	input  dlcws_pkg::dp_status_t   status,
	output dlcws_pkg::dp_op_t       op,
	output logic                    ready
);
	import dlcws_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MA,
		S_DA,
		S_WA,
		S_MB,
		S_DB,
		S_WB,
		S_MED,
		S_MEDR,
		S_F1,
		S_F2,
		S_Q,
		S_WQ,
		S_SHOW,
		S_OUTW
	} state_t;

	state_t  state_q;
	dp_op_t  op_q;
	logic    rdy_q;
	logic    zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_NONE;
			rdy_q <= 1'b1;
			zero_q <= 1'b0;
		end else begin
			op_q <= OP_NONE;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						rdy_q <= 1'b0;
						if (status.cal) begin
							op_q <= OP_MUL_A;
							zero_q <= 1'b0;
							state_q <= S_MA;
						end else begin
							zero_q <= 1'b1;
							state_q <= S_OUTW;
						end
					end
				end
				S_MA: begin
					op_q <= OP_DIV_A;
					state_q <= S_DA;
				end
				S_DA: state_q <= S_WA;
				S_WA: begin
					if (status.div_done) begin
						op_q <= OP_MUL_B;
						state_q <= S_MB;
					end
				end
				S_MB: begin
					op_q <= OP_DIV_B;
					state_q <= S_DB;
				end
				S_DB: state_q <= S_WB;
				S_WB: begin
					if (status.div_done) begin
						op_q <= OP_MED;
						state_q <= S_MED;
					end
				end
				S_MED: begin
					op_q <= OP_MEDR;
					state_q <= S_MEDR;
				end
				S_MEDR: begin
					op_q <= OP_FILT1;
					state_q <= S_F1;
				end
				S_F1: begin
					op_q <= OP_FILT2;
					state_q <= S_F2;
				end
				S_F2: begin
					op_q <= OP_QDIV;
					state_q <= S_Q;
				end
				S_Q: begin
					op_q <= OP_QMUL;
					state_q <= S_WQ;
				end
				S_WQ: begin
					op_q <= OP_SHOW;
					state_q <= S_SHOW;
				end
				S_SHOW: state_q <= S_OUTW;
				S_OUTW: begin
					if (status.out_free) begin
						op_q <= zero_q ? OP_ZERO : OP_EMIT;
						rdy_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					rdy_q <= 1'b1;
				end
			endcase
		end
	end

	assign op = op_q;
	assign ready = rdy_q;

endmodule

>>> hdl/dlcws_dp.sv
module dlcws_dp #(
	parameter int MEDIAN_DEPTH = 3,
	parameter int HOLD_SAMPLES = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dlcws_pkg::dp_op_t                   op,
	input  logic                                in_fire,
	input  logic [dlcws_pkg::IN_W-1:0]          in_data,
	input  logic                                cfg_we,
	input  logic [dlcws_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [dlcws_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [dlcws_pkg::OUT_W-1:0]         out_data,
	output dlcws_pkg::dp_status_t               status
);
	import dlcws_pkg::*;

	localparam int PW = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
	localparam int CW = $clog2(MEDIAN_DEPTH + 1);
	localparam int HW = $clog2(HOLD_SAMPLES + 1);

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// configuration
	logic signed [23:0] tare_a_q, tare_b_q;
	logic signed [31:0] cpg_q;
	logic [8:0]         alpha_s_q, alpha_m_q;
	logic [15:0]        fast_q, dead_q, zrel_q;
	logic               clr;

	assign clr = cfg_we && (cfg_idx == REG_TARE_A || cfg_idx == REG_TARE_B ||
		cfg_idx == REG_CPG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_a_q <= '0;
			tare_b_q <= '0;
			cpg_q <= '0;
			alpha_s_q <= 9'd26;
			alpha_m_q <= 9'd154;
			fast_q <= 16'd1000;
			dead_q <= 16'd300;
			zrel_q <= 16'd350;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TARE_A: tare_a_q <= cfg_data[23:0];
				REG_TARE_B: tare_b_q <= cfg_data[23:0];
				REG_CPG: cpg_q <= cfg_data;
				REG_ALPHA_S: alpha_s_q <= cfg_data[8:0];
				REG_ALPHA_M: alpha_m_q <= cfg_data[8:0];
				REG_FAST: fast_q <= cfg_data[15:0];
				REG_DEAD: dead_q <= cfg_data[15:0];
				REG_ZREL: zrel_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// cell conversion
	logic signed [23:0] raw_a_q, raw_b_q;
	logic signed [24:0] net_a, net_b, net_sel;
	logic signed [51:0] prod_q;
	logic [31:0]        cpg_mag;
	logic [DIV_W-1:0]   prod_mag;
	logic signed [39:0] filt_q;
	logic [39:0]        filt_mag;
	logic               div_start;
	logic [DIV_W-1:0]   div_n;
	logic [31:0]        div_d;
	logic               div_done;
	logic [DIV_W-1:0]   div_q;
	dp_op_t             tgt_q;
	logic               neg_q;
	logic signed [51:0] ca_q, cb_q, div_sq;
	logic [39:0]        qrnd;
	logic [31:0]        qm_q;
	logic [63:0]        qprod;
	logic [25:0]        quo_q;
	logic               quo_neg_q;

	assign net_a = {raw_a_q[23], raw_a_q} - {tare_a_q[23], tare_a_q};
	assign net_b = {raw_b_q[23], raw_b_q} - {tare_b_q[23], tare_b_q};
	assign net_sel = (op == OP_MUL_A) ? net_a : net_b;
	assign cpg_mag = cpg_q[31] ? (~cpg_q + 32'd1) : cpg_q;
	assign prod_mag = prod_q[51] ? DIV_W'(-prod_q) : DIV_W'(prod_q);
	assign filt_mag = filt_q[39] ? 40'(-filt_q) : filt_q;
	assign div_start = (op == OP_DIV_A) || (op == OP_DIV_B);
	assign div_n = prod_mag + DIV_W'(cpg_mag >> 1);
	assign div_d = cpg_mag;
	assign div_sq = neg_q ? -{1'b0, div_q} : {1'b0, div_q};
	// 100 mg quantizer: (|filt| + 12800) >> 8, then divide by 100
	assign qrnd = filt_mag + QUANT_HALF;
	assign qprod = 64'(qm_q) * 64'(Q_RECIP);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			raw_a_q <= in_data[23:0];
			raw_b_q <= in_data[47:24];
		end
		if (op == OP_MUL_A || op == OP_MUL_B)
			prod_q <= net_sel * MG_PER_COUNT_K;
		if (div_start) begin
			tgt_q <= op;
			neg_q <= prod_q[51] ^ cpg_q[31];
		end
		if (div_done) begin
			case (tgt_q)
				OP_DIV_A: ca_q <= div_sq;
				OP_DIV_B: cb_q <= div_sq;
				default: ;
			endcase
		end
		if (op == OP_QDIV) begin
			qm_q <= qrnd[39:8];
			quo_neg_q <= filt_q[39];
		end
		if (op == OP_QMUL)
			quo_q <= qprod[62:37];
	end

	dlcws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	// median window
	logic signed [31:0] hist_q [MEDIAN_DEPTH];
	logic [PW-1:0]      pos_q;
	logic [CW-1:0]      cnt_q;
	logic signed [52:0] rt, rt_q;
	logic [CW-1:0]      rank [MEDIAN_DEPTH];
	logic [CW-1:0]      mid, mid_m1;
	logic signed [31:0] lo_v, hi_v, med;
	logic signed [32:0] pair_sum;
	logic signed [31:0] med_q;

	assign rt = {ca_q[51], ca_q} + {cb_q[51], cb_q};
	assign mid = cnt_q >> 1;
	assign mid_m1 = mid - CW'(1);

	always_comb begin
		for (int i = 0; i < MEDIAN_DEPTH; i++) begin
			rank[i] = '0;
			for (int j = 0; j < MEDIAN_DEPTH; j++) begin
				if (CW'(j) < cnt_q && ((hist_q[j] < hist_q[i]) ||
					(hist_q[j] == hist_q[i] && j < i)))
					rank[i] = rank[i] + CW'(1);
			end
		end
		lo_v = '0;
		hi_v = '0;
		for (int i = 0; i < MEDIAN_DEPTH; i++) begin
			if (CW'(i) < cnt_q) begin
				if (rank[i] == mid)
					hi_v = hist_q[i];
				if (rank[i] == mid_m1)
					lo_v = hist_q[i];
			end
		end
		pair_sum = {lo_v[31], lo_v} + {hi_v[31], hi_v};
		med = cnt_q[0] ? hi_v : pair_sum[32:1];
	end

	always_ff @(posedge clk) begin
		if (op == OP_MED) begin
			hist_q[pos_q] <= sat32({{11{rt[52]}}, rt});
			rt_q <= rt;
		end
		if (op == OP_MEDR)
			med_q <= med;
	end

	// adaptive filter
	logic signed [40:0] fdiff;
	logic [40:0]        fdiff_mag, fdm_q;
	logic               dneg_q;
	logic [8:0]         a_sel, a_q;
	logic [49:0]        fprod;
	logic [50:0]        frnd;
	logic [40:0]        fstep;
	logic signed [40:0] fnext;
	logic               filt_ok_q;

	assign fdiff = {med_q[31], med_q, 8'd0} - {filt_q[39], filt_q};
	assign fdiff_mag = fdiff[40] ? 41'(-fdiff) : fdiff;
	assign a_sel = (fdiff_mag >= {17'd0, fast_q, 8'd0}) ? alpha_m_q : alpha_s_q;
	assign fprod = fdm_q * a_q;
	assign frnd = {1'b0, fprod} + 51'd128;
	assign fstep = frnd[48:8];
	assign fnext = {filt_q[39], filt_q} + (dneg_q ? -fstep : fstep);

	always_ff @(posedge clk) begin
		if (op == OP_FILT1) begin
			fdm_q <= fdiff_mag;
			dneg_q <= fdiff[40];
			a_q <= (a_sel > 9'd256) ? 9'd256 : a_sel;
		end
	end

	// display hold and quantization
	logic [32:0]        qmag;
	logic signed [33:0] qv;
	logic signed [31:0] qsat, q0;
	logic [32:0]        qsat_abs;
	logic signed [31:0] shown_q;
	logic               shown_ok_q;
	logic [HW-1:0]      hold_q, hold_n, hold_inc;
	logic               chg_q, chg_n;
	logic signed [31:0] shown_n, nxt, nxt_z;
	logic signed [40:0] fd;
	logic [40:0]        fd_abs;
	logic signed [32:0] id, nd;
	logic [32:0]        id_abs, nxt_abs, nd_abs;

	assign qmag = quo_q * 7'd100;
	assign qv = quo_neg_q ? -{1'b0, qmag} : {1'b0, qmag};
	assign qsat = sat32({{30{qv[33]}}, qv});
	assign qsat_abs = qsat[31] ? 33'(-{qsat[31], qsat}) : {1'b0, qsat};
	assign q0 = (qsat_abs < {17'd0, zrel_q}) ? '0 : qsat;
	assign fd = {filt_q[39], filt_q} - {shown_q[31], shown_q, 8'd0};
	assign fd_abs = fd[40] ? 41'(-fd) : fd;
	assign id = {med_q[31], med_q} - {shown_q[31], shown_q};
	assign id_abs = id[32] ? 33'(-id) : id;
	assign hold_inc = hold_q + HW'(1);

	always_comb begin
		nxt = shown_q;
		hold_n = '0;
		if (shown_q == '0 && filt_mag < {16'd0, zrel_q, 8'd0}) begin
			hold_n = '0;
		end else if (id_abs >= {17'd0, fast_q}) begin
			nxt = qsat;
		end else if (fd_abs >= {17'd0, dead_q, 8'd0}) begin
			if (hold_inc >= HW'(HOLD_SAMPLES))
				nxt = qsat;
			else
				hold_n = hold_inc;
		end
		nxt_abs = nxt[31] ? 33'(-{nxt[31], nxt}) : {1'b0, nxt};
		nxt_z = (nxt_abs < {17'd0, zrel_q}) ? '0 : nxt;
		nd = {nxt_z[31], nxt_z} - {shown_q[31], shown_q};
		nd_abs = nd[32] ? 33'(-nd) : nd;
		if (!shown_ok_q) begin
			shown_n = q0;
			chg_n = 1'b1;
		end else if (nd_abs >= 33'd50) begin
			shown_n = nxt_z;
			chg_n = 1'b1;
		end else begin
			shown_n = shown_q;
			chg_n = 1'b0;
		end
	end

	// cell split
	logic signed [53:0] corr, ha;
	logic signed [54:0] sa, sb;
	logic signed [31:0] cell_a_q, cell_b_q, new_a, new_b;
	logic               pair_ok_q;

	assign corr = {{22{shown_q[31]}}, shown_q} - {rt_q[52], rt_q};
	assign ha = corr >>> 1;
	assign sa = {{3{ca_q[51]}}, ca_q} + {ha[53], ha};
	assign sb = {{3{cb_q[51]}}, cb_q} + {corr[53], corr} - {ha[53], ha};
	assign new_a = (!pair_ok_q || chg_q) ? sat32({{9{sa[54]}}, sa}) : cell_a_q;
	assign new_b = (!pair_ok_q || chg_q) ? sat32({{9{sb[54]}}, sb}) : cell_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
			filt_q <= '0;
			filt_ok_q <= 1'b0;
			shown_q <= '0;
			shown_ok_q <= 1'b0;
			hold_q <= '0;
			chg_q <= 1'b0;
			cell_a_q <= '0;
			cell_b_q <= '0;
			pair_ok_q <= 1'b0;
		end else if (clr) begin
			pos_q <= '0;
			cnt_q <= '0;
			filt_q <= '0;
			filt_ok_q <= 1'b0;
			shown_q <= '0;
			shown_ok_q <= 1'b0;
			hold_q <= '0;
			chg_q <= 1'b0;
			cell_a_q <= '0;
			cell_b_q <= '0;
			pair_ok_q <= 1'b0;
		end else begin
			case (op)
				OP_MED: begin
					pos_q <= (pos_q == PW'(MEDIAN_DEPTH - 1)) ? '0 : pos_q + PW'(1);
					if (cnt_q < CW'(MEDIAN_DEPTH))
						cnt_q <= cnt_q + CW'(1);
				end
				OP_FILT2: begin
					if (!filt_ok_q) begin
						filt_q <= {med_q, 8'd0};
						filt_ok_q <= 1'b1;
					end else begin
						filt_q <= fnext[39:0];
					end
				end
				OP_SHOW: begin
					shown_q <= shown_n;
					shown_ok_q <= 1'b1;
					chg_q <= chg_n;
					if (shown_ok_q)
						hold_q <= hold_n;
				end
				OP_EMIT: begin
					cell_a_q <= new_a;
					cell_b_q <= new_b;
					pair_ok_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result register
	logic                   ov_q;
	logic [OUT_W-1:0]       od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (op == OP_EMIT || op == OP_ZERO) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_EMIT)
			od_q <= {6'd0, chg_q, 1'b1, shown_q, new_b, new_a};
		else if (op == OP_ZERO)
			od_q <= '0;
	end

	assign out_valid = ov_q;
	assign out_data = od_q;
	assign status.cal = !(cpg_q > -32'sd7 && cpg_q < 32'sd7);
	assign status.out_free = !ov_q || out_ready;
	assign status.div_done = div_done;

endmodule

>>> hdl/dual_load_cell_weight_stabilizer.sv
// Dual load-cell weight stabilizer. Each request on the input stream carries one sample pair;
// one result per request leaves on the output stream. Items are handled one at a time: a
// calibrated item takes two passes of a shared radix-2 divider for the cell conversions,
// then median, filter, 100 mg quantizer, display update and result load; with the scale
// factor below 7 in magnitude a zero result is loaded without them. A result that is not
// taken holds the item in its last state until the output register frees. The result sits
// in an output register, so the next request is taken while it waits. Writes to tare_a,
// tare_b or the scale factor clear the filter history.
module dual_load_cell_weight_stabilizer #(
	parameter int MEDIAN_DEPTH = 3,
	parameter int HOLD_SAMPLES = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [dlcws_pkg::IN_W-1:0]          s_axis_tdata,  // raw_a, raw_b
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// cell_a_mg, cell_b_mg, total_mg, result_valid, total_changed
	output logic [dlcws_pkg::OUT_W-1:0]         m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [dlcws_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [dlcws_pkg::CFG_W-1:0]         cfg_data
);
	import dlcws_pkg::*;

	dp_op_t     op;
	dp_status_t status;
	logic       ready;
	logic       in_fire;

	assign s_axis_tready = ready;
	assign in_fire = s_axis_tvalid && ready;

	dlcws_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.status  (status),
		.op      (op),
		.ready   (ready)
	);

	dlcws_dp #(
		.MEDIAN_DEPTH (MEDIAN_DEPTH),
		.HOLD_SAMPLES (HOLD_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_fire   (in_fire),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.status    (status)
	);

endmodule

>>> hdl/dlcws_chk.sv
module dlcws_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [dlcws_pkg::OUT_W-1:0]         m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	a_uncal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[96] |-> m_axis_tdata[97:0] == '0)
		else $error("invalid result not zero");

	a_changed_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[97] |-> m_axis_tdata[96])
		else $error("change flagged on invalid result");

endmodule

bind dual_load_cell_weight_stabilizer dlcws_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
